// ===== hdl/sdf_pkg.sv =====
// Shared types and constants for the signed decimal formatter.
// Used by sdf_dabble, signed_decimal_formatter and sdf_checker; depends on nothing.
`default_nettype none

package sdf_pkg;

    // Fixed field and storage sizes
    localparam int VALUE_W     = 64;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int MAX_DIGITS  = 20;
    localparam int DIGIT_IDX_W = 5;   // holds a digit index and a digit count 0..20
    localparam int PREC_W      = 7;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int ITER_W      = 7;   // holds a shift count 0..64

    typedef logic [DIGIT_W-1:0] digit_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PLUS_FLAG  = 2'd0,
        REG_SPACE_FLAG = 2'd1,
        REG_PRECISION  = 2'd2,
        REG_SIZE_MODE  = 2'd3
    } cfg_reg_t;

    // Operand size codes
    typedef enum logic [1:0] {
        SIZE_INT32 = 2'd0,
        SIZE_INT16 = 2'd1,
        SIZE_INT8  = 2'd2,
        SIZE_INT64 = 2'd3
    } size_mode_t;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CONV  = 4'b0010,
        ST_COUNT = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    // ASCII characters
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    // Control from the sequencer to the shift-and-adjust unit
    typedef struct packed {
        logic load;
        logic step;
    } dab_ctrl_t;

    // Status back from the shift-and-adjust unit
    typedef struct packed {
        logic [DIGIT_IDX_W-1:0] digit_count;
        digit_t                 rd_digit;
    } dab_status_t;

endpackage

`default_nettype wire

// ===== hdl/signed_decimal_formatter.sv =====
// Signed decimal formatter, top level: configuration registers, sequencer
// and output register. Depends on sdf_pkg and sdf_dabble.
//
// Usage:
//  - Input channel (in_valid/in_ready/value) takes one 64-bit signed value
//    per request. It is cut to the configured size and sign extended.
//  - Output channel (out_valid/out_ready/char_out/is_last/empty_res) gives
//    one request per character: optional sign, then the digits, most
//    significant first, padded with '0' up to the precision. is_last marks
//    the final character. An empty string gives one request with
//    empty_res and is_last set and char_out zero.
//  - Config port: cfg_we writes cfg_data into register cfg_index
//    (0 plus flag, 1 space flag, 2 precision, 3 size mode). The user
//    must write only when idle; the block does not enforce this.
//  - Sequence: after a request is taken the binary-to-BCD unit shifts
//    once per operand bit, a count state finds the digit count, then
//    one character per cycle is loaded into the output register while it
//    is free; in_ready rises once the last character is loaded.
//  - A stalled receiver holds the output register; the sequencer waits.
//  - Reset clears the sequencer, output valid and configuration
//    (precision unspecified, int32 size, no flags).
`default_nettype none

module signed_decimal_formatter #(
    parameter int MAX_PRECISION = 40
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [sdf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sdf_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [sdf_pkg::VALUE_W-1:0] value,
    // output channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [sdf_pkg::CHAR_W-1:0]        char_out,
    output logic                              is_last,
    output logic                              empty_res
);
    import sdf_pkg::*;

    localparam int CNT_MAX = (MAX_PRECISION > MAX_DIGITS) ? MAX_PRECISION : MAX_DIGITS;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    // configuration registers
    logic              plus_reg;
    logic              space_reg;
    logic [PREC_W-1:0] prec_reg;
    size_mode_t        size_reg;

    // sequencer
    state_t            state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic              sign_pend_reg, sign_pend_next;
    logic [CHAR_W-1:0] sign_char_reg, sign_char_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;
    logic              empty_reg, empty_next;

    // datapath
    logic [VALUE_W-1:0] sext;
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] aligned;
    logic [ITER_W-1:0]  op_bits;
    logic               neg;
    logic [CNT_W-1:0]   want;
    logic [CNT_W-1:0]   total;
    logic [CNT_W-1:0]   idx;
    digit_t             digit;
    logic               slot_free;
    dab_ctrl_t          dab_ctrl;
    dab_status_t        dab_status;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plus_reg  <= 1'b0;
            space_reg <= 1'b0;
            prec_reg  <= '1;
            size_reg  <= SIZE_INT32;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PLUS_FLAG:  plus_reg  <= cfg_data[0];
                REG_SPACE_FLAG: space_reg <= cfg_data[0];
                REG_PRECISION:  prec_reg  <= cfg_data[PREC_W-1:0];
                REG_SIZE_MODE:  size_reg  <= size_mode_t'(cfg_data[1:0]);
                default:        ;
            endcase
        end
    end

    // size cut and sign extension
    always_comb
    begin
        case (size_reg)
            SIZE_INT8:
            begin
                sext    = {{(VALUE_W-8){value[7]}}, value[7:0]};
                op_bits = ITER_W'(8);
            end
            SIZE_INT16:
            begin
                sext    = {{(VALUE_W-16){value[15]}}, value[15:0]};
                op_bits = ITER_W'(16);
            end
            SIZE_INT32:
            begin
                sext    = {{(VALUE_W-32){value[31]}}, value[31:0]};
                op_bits = ITER_W'(32);
            end
            default:
            begin
                sext    = value;
                op_bits = ITER_W'(VALUE_W);
            end
        endcase
    end

    assign neg = sext[VALUE_W-1];
    assign mag = neg ? (~sext + 1'b1) : sext;

    // left-align the magnitude so the unit shifts only the operand bits
    always_comb
    begin
        case (size_reg)
            SIZE_INT8:  aligned = {mag[7:0],  {(VALUE_W-8){1'b0}}};
            SIZE_INT16: aligned = {mag[15:0], {(VALUE_W-16){1'b0}}};
            SIZE_INT32: aligned = {mag[31:0], {(VALUE_W-32){1'b0}}};
            default:    aligned = mag;
        endcase
    end

    // digits wanted: unspecified acts like 1, large precision saturates
    always_comb
    begin
        if (prec_reg[PREC_W-1])
            want = CNT_W'(1);
        else if (prec_reg > PREC_W'(MAX_PRECISION))
            want = CNT_W'(MAX_PRECISION);
        else
            want = CNT_W'(prec_reg);
    end

    assign total = (want < CNT_W'(dab_status.digit_count)) ?
                   CNT_W'(dab_status.digit_count) : want;

    // digit read for the current position; positions past the store are '0'
    assign idx   = pos_reg - 1'b1;
    assign digit = (idx < CNT_W'(MAX_DIGITS)) ? dab_status.rd_digit : '0;

    sdf_dabble u_dabble (
        .clk       (clk),
        .ctrl      (dab_ctrl),
        .load_bits (aligned),
        .rd_idx    (idx[DIGIT_IDX_W-1:0]),
        .status    (dab_status)
    );

    assign slot_free = !out_valid_reg || out_ready;

    // sequencer and output register load
    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        pos_next       = pos_reg;
        sign_pend_next = sign_pend_reg;
        sign_char_next = sign_char_reg;
        out_valid_next = out_valid_reg && !out_ready;
        char_next      = char_reg;
        last_next      = last_reg;
        empty_next     = empty_reg;
        dab_ctrl       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    dab_ctrl.load  = 1'b1;
                    iter_next      = op_bits;
                    sign_pend_next = neg || plus_reg || space_reg;
                    sign_char_next = neg ? CHAR_MINUS : (plus_reg ? CHAR_PLUS : CHAR_SPACE);
                    state_next     = ST_CONV;
                end
            end
            ST_CONV:
            begin
                dab_ctrl.step = 1'b1;
                iter_next     = iter_reg - 1'b1;
                if (iter_reg == ITER_W'(1))
                    state_next = ST_COUNT;
            end
            ST_COUNT:
            begin
                pos_next   = total;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    empty_next     = 1'b0;
                    if (sign_pend_reg)
                    begin
                        char_next      = sign_char_reg;
                        last_next      = (pos_reg == '0);
                        sign_pend_next = 1'b0;
                        if (pos_reg == '0)
                            state_next = ST_IDLE;
                    end
                    else if (pos_reg == '0)
                    begin
                        // nothing to print at all
                        char_next  = CHAR_NUL;
                        last_next  = 1'b1;
                        empty_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        char_next = CHAR_ZERO + CHAR_W'(digit);
                        last_next = (pos_reg == CNT_W'(1));
                        pos_next  = pos_reg - 1'b1;
                        if (pos_reg == CNT_W'(1))
                            state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            sign_pend_reg <= 1'b0;
            iter_reg      <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sign_pend_reg <= sign_pend_next;
            iter_reg      <= iter_next;
            pos_reg       <= pos_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sign_char_reg <= sign_char_next;
        char_reg      <= char_next;
        last_reg      <= last_next;
        empty_reg     <= empty_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign char_out  = char_reg;
    assign is_last   = last_reg;
    assign empty_res = empty_reg;

endmodule

`default_nettype wire

// ===== hdl/sdf_dabble.sv =====
// Shift-and-add-3 unit: turns a left-aligned binary magnitude into
// 20 BCD digits, one bit per step. Depends on sdf_pkg.
`default_nettype none

module sdf_dabble (
    input  logic                           clk,
    input  sdf_pkg::dab_ctrl_t             ctrl,
    input  logic [sdf_pkg::VALUE_W-1:0]    load_bits,
    input  logic [sdf_pkg::DIGIT_IDX_W-1:0] rd_idx,
    output sdf_pkg::dab_status_t           status
);
    import sdf_pkg::*;

    digit_t               digit_reg [MAX_DIGITS];
    digit_t               digit_next [MAX_DIGITS];
    digit_t               adj [MAX_DIGITS];
    logic [VALUE_W-1:0]   bin_reg;
    logic [VALUE_W-1:0]   bin_next;
    logic [DIGIT_IDX_W-1:0] count;

    // Add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            adj[i] = (digit_reg[i] >= 4'd5) ? digit_reg[i] + 4'd3 : digit_reg[i];
        end
    end

    // Load or one shift step across the BCD digits and the binary word
    always_comb
    begin
        digit_next = digit_reg;
        bin_next   = bin_reg;
        if (ctrl.load)
        begin
            for (int i = 0; i < MAX_DIGITS; i++)
            begin
                digit_next[i] = '0;
            end
            bin_next = load_bits;
        end
        else if (ctrl.step)
        begin
            digit_next[0] = {adj[0][DIGIT_W-2:0], bin_reg[VALUE_W-1]};
            for (int i = 1; i < MAX_DIGITS; i++)
            begin
                digit_next[i] = {adj[i][DIGIT_W-2:0], adj[i-1][DIGIT_W-1]};
            end
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
        bin_reg   <= bin_next;
    end

    // Significant digit count: highest nonzero digit plus one
    always_comb
    begin
        count = '0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (digit_reg[i] != '0)
            begin
                count = DIGIT_IDX_W'(i + 1);
            end
        end
    end

    assign status.digit_count = count;
    assign status.rd_digit    = (rd_idx < DIGIT_IDX_W'(MAX_DIGITS)) ? digit_reg[rd_idx] : '0;

endmodule

`default_nettype wire

// ===== hdl/sdf_checker.sv =====
// Port-level checks for the signed decimal formatter, bound to the top level.
// Depends on sdf_pkg and signed_decimal_formatter.
`default_nettype none

module sdf_port_assert (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [sdf_pkg::CHAR_W-1:0]        char_out,
    input  logic                              is_last,
    input  logic                              empty_res
);
    import sdf_pkg::*;

    // a stalled result request stays up
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(char_out) && $stable(is_last) && $stable(empty_res))
        else $error("result payload changed while stalled");

    // one item at a time: no new request right after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready high right after a request was taken");

    // an empty result is the whole string
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_res |-> is_last && (char_out == CHAR_NUL))
        else $error("empty result not marked last or not zero");

    // every printed character is a digit or a sign
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !empty_res |->
            ((char_out >= CHAR_ZERO) && (char_out <= CHAR_NINE)) ||
            (char_out == CHAR_MINUS) || (char_out == CHAR_PLUS) ||
            (char_out == CHAR_SPACE))
        else $error("unexpected character");

endmodule

bind signed_decimal_formatter sdf_port_assert u_sdf_port_assert (.*);

`default_nettype wire

// ===== verif/sdf_checker.sv =====
// Checker for the signed decimal formatter: watches the config port and both
// channels, predicts the character stream of every value and compares it.
// Depends on sdf_pkg.
`default_nettype none

module sdf_checker
    import sdf_pkg::*;
#(
    parameter int MAX_PRECISION = 40
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                      in_valid,
    input  wire logic                      in_ready,
    input  wire logic signed [VALUE_W-1:0] value,
    input  wire logic                      out_valid,
    input  wire logic                      out_ready,
    input  wire logic [CHAR_W-1:0]         char_out,
    input  wire logic                      is_last,
    input  wire logic                      empty_res,
    output int                             fail_count,
    output int                             chars_pending,
    output int                             chars_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
        logic              blank;
    } char_res_t;

    // Shadow copy of the format registers
    logic              plus_set;
    logic              space_set;
    logic [PREC_W-1:0] prec_set;
    size_mode_t        size_set;

    char_res_t expected_chars[$];

    // Expected characters of one value under the current format settings
    function automatic void format_decimal(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] ext;
        logic [VALUE_W-1:0] mag;
        logic               neg;
        digit_t             digs[MAX_DIGITS];
        int                 ndig;
        int                 want;
        int                 total;
        int                 k;
        logic               has_sign;
        logic [CHAR_W-1:0]  sign_code;
        logic [CHAR_W-1:0]  dcode;

        // cut to operand size and sign extend
        case (size_set)
            SIZE_INT8:  ext = {{56{v[7]}}, v[7:0]};
            SIZE_INT16: ext = {{48{v[15]}}, v[15:0]};
            SIZE_INT32: ext = {{32{v[31]}}, v[31:0]};
            default:    ext = v;
        endcase
        neg = ext[VALUE_W-1];
        mag = neg ? (~ext + 64'd1) : ext;

        // digits, least significant first
        ndig = 0;
        while (mag != 0 && ndig < MAX_DIGITS) begin
            digs[ndig] = digit_t'(mag % 64'd10);
            mag = mag / 64'd10;
            ndig++;
        end

        // negative precision means unspecified; large ones saturate
        if (prec_set[PREC_W-1])
            want = 1;
        else if (int'(prec_set) > MAX_PRECISION)
            want = MAX_PRECISION;
        else
            want = int'(prec_set);
        if (want < ndig)
            want = ndig;

        has_sign  = 1'b1;
        sign_code = CHAR_NUL;
        if (neg)
            sign_code = CHAR_MINUS;
        else if (plus_set)
            sign_code = CHAR_PLUS;
        else if (space_set)
            sign_code = CHAR_SPACE;
        else
            has_sign = 1'b0;

        total = want + int'(has_sign);
        if (total == 0) begin
            expected_chars.push_back(char_res_t'{code: CHAR_NUL, last: 1'b1, blank: 1'b1});
            return;
        end

        k = 0;
        if (has_sign) begin
            expected_chars.push_back(char_res_t'{code: sign_code, last: (total == 1),
                                                 blank: 1'b0});
            k = 1;
        end
        for (int i = want; i > 0; i--) begin
            dcode = CHAR_ZERO;
            if (i - 1 < ndig)
                dcode = CHAR_ZERO + CHAR_W'(digs[i-1]);
            k++;
            expected_chars.push_back(char_res_t'{code: dcode, last: (k == total),
                                                 blank: 1'b0});
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        char_res_t exp_char;
        int        errs;
        if (!rst_n) begin
            plus_set  = 1'b0;
            space_set = 1'b0;
            prec_set  = '1;
            size_set  = SIZE_INT32;
            expected_chars.delete();
            chars_pending <= 0;
        end else begin
            errs = 0;
            // register writes
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_PLUS_FLAG:  plus_set  = cfg_data[0];
                    REG_SPACE_FLAG: space_set = cfg_data[0];
                    REG_PRECISION:  prec_set  = cfg_data[PREC_W-1:0];
                    REG_SIZE_MODE:  size_set  = size_mode_t'(cfg_data[1:0]);
                    default: ;
                endcase
            end

            // accepted value request
            if (in_valid && in_ready)
                format_decimal(value);

            // accepted character request
            if (out_valid && out_ready) begin
                chars_checked <= chars_checked + 1;
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected character request: char %h last %b empty %b",
                             $time, char_out, is_last, empty_res);
                    errs++;
                end else begin
                    exp_char = expected_chars.pop_front();
                    // char_out carries no meaning on an empty string
                    if (!exp_char.blank && char_out !== exp_char.code) begin
                        $display("%0t: char_out mismatch: expected %h actual %h",
                                 $time, exp_char.code, char_out);
                        errs++;
                    end
                    if (is_last !== exp_char.last) begin
                        $display("%0t: is_last mismatch: expected %b actual %b",
                                 $time, exp_char.last, is_last);
                        errs++;
                    end
                    if (empty_res !== exp_char.blank) begin
                        $display("%0t: empty_res mismatch: expected %b actual %b",
                                 $time, exp_char.blank, empty_res);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
            chars_pending <= expected_chars.size();
        end
    end

endmodule

`default_nettype wire

// ===== verif/tb_signed_decimal_formatter.sv =====
// Testbench top for the signed decimal formatter: clock, reset, format
// settings, value requests and receiver back-pressure, plus the verdict.
// Depends on sdf_pkg, signed_decimal_formatter and sdf_checker.
`default_nettype none

module tb_signed_decimal_formatter;
    timeunit 1ns;
    timeprecision 1ps;

    import sdf_pkg::*;

    localparam int MAX_PREC         = 40;
    localparam int SEGMENTS         = 11;
    localparam int SEG_ITEMS        = 28;
    localparam int LONG_HOLD_CYCLES = 400;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [VALUE_W-1:0] value;
    logic                      out_valid;
    logic                      out_ready;
    logic [CHAR_W-1:0]         char_out;
    logic                      is_last;
    logic                      empty_res;

    int   fail_count;
    int   chars_pending;
    int   chars_checked;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic long_hold;
    int   items_sent;
    int   settings_used;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    signed_decimal_formatter #(
        .MAX_PRECISION (MAX_PREC)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_out  (char_out),
        .is_last   (is_last),
        .empty_res (empty_res)
    );

    sdf_checker #(
        .MAX_PRECISION (MAX_PREC)
    ) fmt_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .char_out      (char_out),
        .is_last       (is_last),
        .empty_res     (empty_res),
        .fail_count    (fail_count),
        .chars_pending (chars_pending),
        .chars_checked (chars_checked)
    );

    // Offer one value request and hold it until taken
    task automatic send_value(input logic [VALUE_W-1:0] v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Drop valid and let every expected character come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (chars_pending != 0);
        repeat (8) @(posedge clk);
    endtask

    // Write all four format registers back to back
    task automatic load_format(input logic plus, input logic space,
                               input logic [PREC_W-1:0] prec, input size_mode_t sz);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PLUS_FLAG;
        cfg_data  <= CFG_DATA_W'(plus);
        @(posedge clk);
        cfg_index <= REG_SPACE_FLAG;
        cfg_data  <= CFG_DATA_W'(space);
        @(posedge clk);
        cfg_index <= REG_PRECISION;
        cfg_data  <= CFG_DATA_W'(prec);
        @(posedge clk);
        cfg_index <= REG_SIZE_MODE;
        cfg_data  <= CFG_DATA_W'(sz);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Receiver: random stalls, or one long hold when asked
    initial
    begin
        out_ready = 1'b0;
        long_hold = 1'b0;
        forever begin
            @(posedge clk);
            if (long_hold) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Run limit
    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        value         = '0;
        items_sent    = 0;
        settings_used = 0;
        send_idle_pct = 30;
        recv_idle_pct = 69;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset format: unspecified precision, int32, no flags
        send_value(64'd0);
        send_value(64'd1);
        send_value(-64'sd1);
        send_value(64'h0000_0000_7FFF_FFFF);
        send_value(64'hFFFF_FFFF_8000_0000);
        send_value(64'h0000_0001_0000_0000);   // truncates to zero
        send_value(64'h1234_5678_FFFF_FFFF);   // truncates to -1

        // zero with precision zero and no sign gives the empty string
        wait_idle();
        load_format(1'b0, 1'b0, 7'd0, SIZE_INT64);
        send_value(64'd0);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'h7FFF_FFFF_FFFF_FFFF);

        // plus sign only on zero
        wait_idle();
        load_format(1'b1, 1'b0, 7'd0, SIZE_INT16);
        send_value(64'd0);
        send_value(64'h0000_0000_0000_8000);
        send_value(64'h0000_0000_0000_7FFF);

        wait_idle();
        load_format(1'b0, 1'b1, 7'd1, SIZE_INT8);
        send_value(64'd0);
        send_value(64'h0000_0000_0000_0080);
        send_value(64'h0000_0000_0000_007F);
        send_value(64'hFFFF_FFFF_FFFF_FF7F);

        // plus wins over space; widest precision on the most negative value
        wait_idle();
        load_format(1'b1, 1'b1, 7'd40, SIZE_INT64);
        send_value(64'd0);
        send_value(64'h8000_0000_0000_0000);

        // precision above the maximum saturates
        wait_idle();
        load_format(1'b0, 1'b0, 7'd63, SIZE_INT32);
        send_value(64'd5);

        // most negative precision acts as unspecified
        wait_idle();
        load_format(1'b0, 1'b1, 7'h40, SIZE_INT16);
        send_value(64'd0);
        send_value(-64'sd7);

        wait_idle();
        load_format(1'b0, 1'b0, 7'd41, SIZE_INT32);
        send_value(64'd1);

        // random segments, each under its own format setting
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            logic [PREC_W-1:0] prec;
            wait_idle();
            if (seg < 4) begin
                send_idle_pct = 30;
                recv_idle_pct = 69;
            end else if (seg < 8) begin
                send_idle_pct = 69;
                recv_idle_pct = 30;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(0, 5))
                0:       prec = '1;
                1:       prec = '0;
                2:       prec = PREC_W'($urandom_range(1, 40));
                3:       prec = PREC_W'($urandom_range(41, 63));
                4:       prec = 7'h40 + PREC_W'($urandom_range(0, 62));
                default: prec = PREC_W'($urandom_range(1, 12));
            endcase
            load_format(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), prec,
                        size_mode_t'($urandom_range(0, 3)));
            // receiver stops for a long stretch so the input backs up
            if (seg == 9)
                long_hold = 1'b1;
            repeat (SEG_ITEMS) begin : rand_item
                logic [VALUE_W-1:0] v;
                logic [VALUE_W-1:0] p;
                int                 w;
                case ($urandom_range(0, 5))
                    1: begin
                        v = VALUE_W'($urandom_range(0, 999));
                        if ($urandom_range(0, 1))
                            v = -v;
                    end
                    2: begin
                        // boundaries of one operand size, junk above it
                        w = 8 << $urandom_range(0, 3);
                        p = (64'd1 << (w - 1)) - 64'd1;
                        case ($urandom_range(0, 3))
                            0:       v = p;
                            1:       v = ~p;
                            2:       v = '0;
                            default: v = '1;
                        endcase
                        if ($urandom_range(0, 1))
                            v = v ^ ({$urandom, $urandom} << w);
                    end
                    3: begin
                        // around a power of ten
                        p = 64'd1;
                        repeat ($urandom_range(0, 19)) p = p * 64'd10;
                        v = p - VALUE_W'($urandom_range(0, 1));
                        if ($urandom_range(0, 1))
                            v = -v;
                    end
                    default: v = {$urandom, $urandom};
                endcase
                send_value(v);
            end
        end

        wait_idle();
        repeat (40) @(posedge clk);
        $display("Sent %0d values under %0d format settings, checked %0d characters,",
                 items_sent, settings_used, chars_checked);
        $display("with sender and receiver stalls, a long receiver hold and no-stall runs.");
        if (fail_count == 0 && chars_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
